// ===== sv/dtem_pkg.sv =====
package dtem_pkg;

    // text lengths per mode
    localparam logic [4:0] CMP_LEN = 5'd14;
    localparam logic [4:0] SEP_LEN = 5'd19;
    localparam logic [4:0] POS_MAX = 5'd31;

    // separator slot codes; digit slots are 0..13
    localparam logic [4:0] SLOT_DASH  = 5'd14;
    localparam logic [4:0] SLOT_GAP   = 5'd15;
    localparam logic [4:0] SLOT_COLON = 5'd16;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // register map
    localparam logic ADDR_FORMAT_MODE = 1'b0;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_LEAP,
        B_DAYS,
        B_SCALE,
        B_SUM
    } t_back_state;

    // one decoded text, handed from parser to the date math
    typedef struct packed {
        logic        err;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
    } t_job;

    // character position -> slot, separated mode
    function automatic logic [4:0] sep_slot(input logic [4:0] pos);
        logic [4:0] s;
        unique case (pos)
            5'd0:  s = 5'd0;
            5'd1:  s = 5'd1;
            5'd2:  s = 5'd2;
            5'd3:  s = 5'd3;
            5'd4:  s = SLOT_DASH;
            5'd5:  s = 5'd4;
            5'd6:  s = 5'd5;
            5'd7:  s = SLOT_DASH;
            5'd8:  s = 5'd6;
            5'd9:  s = 5'd7;
            5'd10: s = SLOT_GAP;
            5'd11: s = 5'd8;
            5'd12: s = 5'd9;
            5'd13: s = SLOT_COLON;
            5'd14: s = 5'd10;
            5'd15: s = 5'd11;
            5'd16: s = SLOT_COLON;
            5'd17: s = 5'd12;
            5'd18: s = 5'd13;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] mon);
        logic [8:0] d;
        unique case (mon)
            4'd0:  d = 9'd0;
            4'd1:  d = 9'd31;
            4'd2:  d = 9'd59;
            4'd3:  d = 9'd90;
            4'd4:  d = 9'd120;
            4'd5:  d = 9'd151;
            4'd6:  d = 9'd181;
            4'd7:  d = 9'd212;
            4'd8:  d = 9'd243;
            4'd9:  d = 9'd273;
            4'd10: d = 9'd304;
            4'd11: d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/dtem_front.sv =====
module dtem_front import dtem_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_mode,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    input  logic       i_last,
    input  logic       i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_job       o_job
);

    logic [4:0] r_pos,  n_pos;
    logic [3:0] r_tens, n_tens;
    logic [13:0] r_year, n_year;
    logic [6:0] r_month, n_month, r_day, n_day, r_hour, n_hour;
    logic [6:0] r_minute, n_minute, r_second, n_second;
    logic       r_err, n_err;

    logic       accept;
    logic [4:0] limit;
    logic [4:0] slot;
    logic       is_digit;
    logic [3:0] digit;
    logic [6:0] pair;

    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign limit    = i_mode ? SEP_LEN : CMP_LEN;
    assign slot     = i_mode ? sep_slot(r_pos) : r_pos;
    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign digit    = i_char[3:0];
    assign pair     = 7'({3'b000, r_tens} * 7'd10) + {3'b000, digit};

    always_comb begin
        n_pos    = r_pos;
        n_tens   = r_tens;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_err    = r_err;
        o_push   = 1'b0;
        o_job    = '0;

        if (accept) begin
            priority if (r_pos >= limit) begin
                n_err = 1'b1;
            end else if (slot == SLOT_DASH) begin
                if (i_char != CH_DASH) n_err = 1'b1;
            end else if (slot == SLOT_GAP) begin
                if (i_char != CH_SPACE && i_char != CH_T) n_err = 1'b1;
            end else if (slot == SLOT_COLON) begin
                if (i_char != CH_COLON) n_err = 1'b1;
            end else if (!is_digit) begin
                n_err = 1'b1;
            end else if (!slot[0]) begin
                n_tens = digit;
            end else begin
                unique case (slot[3:1])
                    3'd0: n_year   = 14'({7'b0, pair} * 14'd100);
                    3'd1: n_year   = r_year + {7'b0, pair};
                    3'd2: n_month  = pair;
                    3'd3: n_day    = pair;
                    3'd4: n_hour   = pair;
                    3'd5: n_minute = pair;
                    default: n_second = pair;
                endcase
            end

            if (r_pos < POS_MAX) n_pos = r_pos + 5'd1;

            if (i_last) begin
                // length judged with the mode in force now
                o_push       = 1'b1;
                o_job.err    = n_err || (n_pos != limit);
                o_job.year   = n_year;
                o_job.month  = n_month;
                o_job.day    = n_day;
                o_job.hour   = n_hour;
                o_job.minute = n_minute;
                o_job.second = n_second;
                n_pos    = '0;
                n_tens   = '0;
                n_year   = '0;
                n_month  = '0;
                n_day    = '0;
                n_hour   = '0;
                n_minute = '0;
                n_second = '0;
                n_err    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_tens   <= '0;
            r_year   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_err    <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_tens   <= n_tens;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_err    <= n_err;
        end
    end

endmodule

// ===== sv/dtem_queue.sv =====
module dtem_queue import dtem_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= !r_wr;
            if (i_pop && o_valid)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0)
                           - 2'((i_pop && o_valid) ? 1 : 0);
        end
    end

endmodule

// ===== sv/dtem_back.sv =====
module dtem_back import dtem_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_job        i_q_job,
    output logic        o_q_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,
    output logic [1:0]  o_m_tuser
);

    t_back_state r_state, n_state;

    t_job         r_job;
    t_status      r_stat;
    logic [3:0]   r_mon;
    logic [14:0]  r_year;
    logic [14:0]  r_yoff;
    logic [12:0]  r_lyq4;
    logic [7:0]   r_q100;
    logic [23:0]  r_days;
    logic signed [49:0] r_tday;
    logic [18:0]  r_tod;

    logic         r_m_tvalid;
    logic [47:0]  r_m_tdata;
    logic [1:0]   r_m_tuser;

    // month carry: mon0 / 12 via reciprocal, exact for mon0 < 128
    logic [6:0]   mon0;
    logic [14:0]  div12_prod;
    logic [3:0]   q12;
    // leap counts
    logic [14:0]  ly;
    logic [14:0]  ly_off;
    logic [27:0]  div100_prod;
    logic [23:0]  days_sum;
    logic signed [49:0] t_total;
    t_status      fin_stat;
    logic         out_free;

    assign mon0        = r_job.month - 7'd1;
    assign div12_prod  = {8'b0, mon0} * 15'd171;
    assign q12         = div12_prod[14:11];

    assign ly          = (r_mon <= 4'd1) ? (r_year - 15'd1) : r_year;
    assign ly_off      = ly - 15'd1900;
    assign div100_prod = {13'b0, ly_off} * 28'd5243;

    // floor((ly-1600)/400) = floor((floor((ly-1900)/100) + 3) / 4)
    assign days_sum = 24'(r_yoff) * 24'd365
                    + 24'(days_before_month(r_mon))
                    + 24'(r_lyq4)
                    + 24'((9'(r_q100) + 9'd3) >> 2)
                    + 24'(r_job.day)
                    - 24'(r_q100)
                    - 24'd1;

    assign t_total  = r_tday + 50'($signed({1'b0, 29'({10'b0, r_tod} * 29'd1000)}));
    assign fin_stat = (r_stat == ST_OK && t_total < 0) ? ST_RANGE : r_stat;
    assign out_free = !r_m_tvalid || i_m_tready;

    assign o_q_pop    = (r_state == B_IDLE) && i_q_valid;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (i_q_valid) n_state = B_DIV;
            B_DIV:   n_state = B_LEAP;
            B_LEAP:  n_state = B_DAYS;
            B_DAYS:  n_state = B_SCALE;
            B_SCALE: n_state = B_SUM;
            B_SUM:   if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= B_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) r_job <= i_q_job;
            end
            B_DIV: begin
                r_mon  <= 4'(mon0 - 7'({3'b0, q12} * 7'd12));
                r_year <= {1'b0, r_job.year} + {11'b0, q12};
                if (r_job.err)                 r_stat <= ST_MALFORMED;
                else if (r_job.month == 7'd0)  r_stat <= ST_RANGE;
                else                           r_stat <= ST_OK;
            end
            B_LEAP: begin
                if (r_stat == ST_OK && r_year < 15'd1970) r_stat <= ST_RANGE;
                r_yoff <= r_year - 15'd1970;
                r_lyq4 <= 13'((ly - 15'd1968) >> 2);
                r_q100 <= div100_prod[26:19];
            end
            B_DAYS: begin
                r_days <= days_sum;
            end
            B_SCALE: begin
                r_tday <= 50'($signed(r_days) * 28'sd86400000);
                r_tod  <= 19'({12'b0, r_job.hour} * 19'd3600)
                        + 19'({12'b0, r_job.minute} * 19'd60)
                        + {12'b0, r_job.second};
            end
            B_SUM: ;
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == B_SUM && out_free) begin
            r_m_tdata <= (fin_stat == ST_OK) ? t_total[47:0] : 48'd0;
            r_m_tuser <= fin_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (r_state == B_SUM && out_free) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

endmodule

// ===== sv/datetime_text_to_epoch_ms.sv =====
// Channel     | Handshake              | Payload
// ------------+------------------------+---------------------------------------------
// text in     | s_tvalid / s_tready    | s_tdata = char_code[7:0], s_tlast = last_char
// result out  | m_tvalid / m_tready    | m_tdata = epoch_ms[47:0], m_tuser = status
// config      | psel/penable/pwrite    | 0x0: format_mode (bit 0)
//
// Characters are taken one per cycle while the request queue has room; s_tready
// drops only when two finished texts are already queued for the date math.
// Each finished text goes through the date unit's steps (queue pop, month carry,
// leap counts, day count, scale to ms, final sum), split to keep each one short.
// With no output stall, texts of 6 or more characters keep input at full pace; a
// run of shorter (malformed) texts fills the queue and stalls input.
// Reset is synchronous, active low, and clears the parser, queue, date unit and
// format_mode; it acts on the next rising clock edge, with no clearing pass.
// A stalled result holds in the output register; the parser keeps going until
// the queue behind it is full.
module datetime_text_to_epoch_ms import dtem_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // text stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_char
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [47:0] epoch_ms
    output logic [1:0]  m_tuser,   // [1:0] status
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic r_mode;
    logic cfg_wr;

    // parser -> queue -> date unit
    logic q_push, q_full, q_valid, q_pop;
    t_job push_job, pop_job;

    // only format_mode exists; paddr bits [1:0] are not decoded
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == ADDR_FORMAT_MODE) ? {31'b0, r_mode} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (cfg_wr && paddr[2] == ADDR_FORMAT_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    // front: checks each character against the mode and builds the fields
    dtem_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_valid (s_tvalid),
        .i_char  (s_tdata),
        .i_last  (s_tlast),
        .i_full  (q_full),
        .o_ready (s_tready),
        .o_push  (q_push),
        .o_job   (push_job)
    );

    // two-deep request queue between parser and date math
    dtem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    // back: calendar arithmetic and result register
    dtem_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_job    (pop_job),
        .o_q_pop    (q_pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

endmodule

// ===== sv/dtem_checker.sv =====
module dtem_checker import dtem_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        pready
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // failed conversions carry no time
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == 48'd0)
        else $error("nonzero epoch_ms with error status");

    // no status code beyond out of range
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_MALFORMED || m_tuser == ST_RANGE)
        else $error("bad status code");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind datetime_text_to_epoch_ms dtem_checker u_dtem_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

// ===== bench/datetime_text_to_epoch_ms_test.sv =====
`timescale 1ns / 100ps

module datetime_text_to_epoch_ms_test;
    import dtem_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 16;   // room for the date unit to finish
    localparam int DRAIN_CYCLES  = 24;
    localparam int STALL_HOLD    = 400;  // long output hold-off, in cycles
    localparam int PHASE_CHARS   = 90;
    localparam logic [2:0] MODE_ADDR = {ADDR_FORMAT_MODE, 2'b00};

    // one result as the block should produce it
    typedef struct packed {
        logic [47:0] ms;
        t_status     st;
    } t_epoch_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] char_code
    logic        s_tlast;   // last_char
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // [47:0] epoch_ms
    logic [1:0]  m_tuser;   // [1:0] status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    datetime_text_to_epoch_ms i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the register and the parse state
    // ------------------------------------------------------------------
    logic        cfg_mode;
    logic [4:0]  text_pos;
    logic [3:0]  tens_acc;
    logic [13:0] year_acc;
    logic [6:0]  month_acc, day_acc, hour_acc, minute_acc, second_acc;
    logic        text_bad;

    const int cum_days[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    t_epoch_result epochs_due[$];   // results owed by the block, oldest first

    int fault_count;
    int chars_taken;
    int results_seen, ok_seen, malformed_seen, range_seen;

    // stimulus controls
    logic        cur_mode;
    bit          src_gaps;
    bit          sink_gaps;
    int          sink_hold;
    int          sink_stall;
    logic [7:0]  text_buf [0:31];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // separated layout: separator kind, or digit slot 0..13
    function automatic logic [4:0] text_slot(input logic [4:0] pos);
        case (pos)
            5'd4, 5'd7:   return SLOT_DASH;
            5'd10:        return SLOT_GAP;
            5'd13, 5'd16: return SLOT_COLON;
            default:      return pos - 5'(pos > 4) - 5'(pos > 7) - 5'(pos > 10)
                                     - 5'(pos > 13) - 5'(pos > 16);
        endcase
    endfunction

    function automatic void clear_text();
        text_pos   = '0;
        tens_acc   = '0;
        year_acc   = '0;
        month_acc  = '0;
        day_acc    = '0;
        hour_acc   = '0;
        minute_acc = '0;
        second_acc = '0;
        text_bad   = 1'b0;
    endfunction

    // even slot keeps the tens digit, odd slot completes a two-digit field
    function automatic void take_digit(input logic [4:0] slot, input logic [7:0] ch);
        int v;
        if (ch < CH_ZERO || ch > CH_NINE) begin
            text_bad = 1'b1;
            return;
        end
        if (!slot[0]) begin
            tens_acc = 4'(ch - CH_ZERO);
            return;
        end
        v = int'(tens_acc) * 10 + int'(ch - CH_ZERO);
        case (slot[4:1])
            4'd0:    year_acc   = 14'(v * 100);
            4'd1:    year_acc   = 14'(int'(year_acc) + v);
            4'd2:    month_acc  = 7'(v);
            4'd3:    day_acc    = 7'(v);
            4'd4:    hour_acc   = 7'(v);
            4'd5:    minute_acc = 7'(v);
            default: second_acc = 7'(v);
        endcase
    endfunction

    // date math for the text just closed
    function automatic t_epoch_result settle_text();
        t_epoch_result r;
        int     mon0, yr, mon, ly;
        int     dy, hr, mi, se;
        longint days, t;
        r.ms = '0;
        r.st = ST_OK;
        if (text_pos != (cfg_mode ? SEP_LEN : CMP_LEN))
            text_bad = 1'b1;
        if (text_bad) begin
            r.st = ST_MALFORMED;
        end else if (month_acc == 0) begin
            r.st = ST_RANGE;
        end else begin
            // months past 12 roll into the year
            mon0 = int'(month_acc) - 1;
            yr   = int'(year_acc) + mon0 / 12;
            mon  = mon0 % 12;
            if (yr < 1970) begin
                r.st = ST_RANGE;
            end else begin
                dy = int'(day_acc);
                hr = int'(hour_acc);
                mi = int'(minute_acc);
                se = int'(second_acc);
                // Jan/Feb count leap days up to the previous year
                ly = (mon <= 1) ? yr - 1 : yr;
                days = longint'(yr - 1970) * 365 + cum_days[mon]
                     + (ly - 1968) / 4 - (ly - 1900) / 100 + (ly - 1600) / 400
                     + dy - 1;
                t = ((days * 24 + hr) * 60 + mi) * 60 + se;
                t = t * 1000;
                if (t < 0)
                    r.st = ST_RANGE;
                else
                    r.ms = 48'(t);
            end
        end
        return r;
    endfunction

    function automatic void absorb_char(input logic [7:0] ch, input logic last,
                                        output bit fires, output t_epoch_result r);
        logic [4:0] slot;
        fires = 1'b0;
        r = '0;
        if (text_pos >= (cfg_mode ? SEP_LEN : CMP_LEN)) begin
            text_bad = 1'b1;
        end else if (!cfg_mode) begin
            take_digit(text_pos, ch);
        end else begin
            slot = text_slot(text_pos);
            case (slot)
                SLOT_DASH:  if (ch != CH_DASH) text_bad = 1'b1;
                SLOT_GAP:   if (ch != CH_SPACE && ch != CH_T) text_bad = 1'b1;
                SLOT_COLON: if (ch != CH_COLON) text_bad = 1'b1;
                default:    take_digit(slot, ch);
            endcase
        end
        if (text_pos < POS_MAX)
            text_pos = text_pos + 5'd1;
        if (last) begin
            fires = 1'b1;
            r = settle_text();
            clear_text();
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t ns: cycle limit hit, %0d results still owed", $time, epochs_due.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Monitor: register writes, accepted requests, result checks
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_epoch_result want;
        bit fires;
        if (!i_rst_n) begin
            cfg_mode = 1'b0;
            clear_text();
        end else begin
            if (psel && penable && pwrite && pready && paddr == MODE_ADDR)
                cfg_mode = pwdata[0];
            // predict before checking, so the queue is current either way
            if (s_tvalid && s_tready) begin
                chars_taken++;
                absorb_char(s_tdata, s_tlast, fires, want);
                if (fires)
                    epochs_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                case (m_tuser)
                    ST_OK:        ok_seen++;
                    ST_MALFORMED: malformed_seen++;
                    default:      range_seen++;
                endcase
                if (epochs_due.size() == 0) begin
                    fault_count++;
                    $display("%0t ns: result with no text pending: epoch_ms %0d status %0d",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = epochs_due.pop_front();
                    if (m_tdata !== want.ms) begin
                        fault_count++;
                        $display("%0t ns: epoch_ms expected %0d, got %0d",
                                 $time, want.ms, m_tdata);
                    end
                    if (m_tuser !== want.st) begin
                        fault_count++;
                        $display("%0t ns: status expected %0d, got %0d",
                                 $time, want.st, m_tuser);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts, plus a long hold when asked
    // ------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                sink_stall = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; all are entered and left at a falling edge
    // ------------------------------------------------------------------

    // one character request; tvalid stays up afterwards for back-to-back use
    task automatic send_char(input logic [7:0] ch, input logic last);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_str(input string txt, input bit ends_text);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], ends_text && i == txt.len() - 1);
    endtask

    task automatic send_text(input int n);
        for (int i = 0; i < n; i++)
            send_char(text_buf[i], i == n - 1);
    endtask

    // sender stops and waits until every owed result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (epochs_due.size() != 0);
    endtask

    // write format_mode over the register port, then read it back
    task automatic write_mode(input logic mode);
        logic [31:0] wd;
        wait_drained();
        // a half-parsed text may still be held in the parser
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        wd = $urandom;
        wd[0] = mode;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= MODE_ADDR;
        pwdata  <= wd;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(mode)) begin
            fault_count++;
            $display("%0t ns: format_mode readback expected %0d, got %0d",
                     $time, mode, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_mode = mode;
    endtask

    // well-formed layout of the given fields into text_buf
    function automatic void fill_text(input logic mode, input int y, mo, d, h, mi, se,
                                      input logic [7:0] gap);
        int pairs[7];
        int slot, digit;
        pairs = '{y / 100, y % 100, mo, d, h, mi, se};
        for (int p = 0; p < (mode ? SEP_LEN : CMP_LEN); p++) begin
            slot = mode ? int'(text_slot(5'(p))) : p;
            case (slot)
                SLOT_DASH:  text_buf[p] = CH_DASH;
                SLOT_GAP:   text_buf[p] = gap;
                SLOT_COLON: text_buf[p] = CH_COLON;
                default: begin
                    digit = slot[0] ? pairs[slot / 2] % 10 : pairs[slot / 2] / 10;
                    text_buf[p] = CH_ZERO + 8'(digit);
                end
            endcase
        end
    endfunction

    // mostly the usual range, now and then anything two digits hold
    function automatic int pick_field(input int lo, input int hi);
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 99);
        return $urandom_range(lo, hi);
    endfunction

    function automatic int pick_year();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 9999);
            1:       return $urandom_range(1960, 1969);
            2:       return $urandom_range(9900, 9999);
            default: return $urandom_range(1970, 2400);
        endcase
    endfunction

    task automatic send_random_text(input logic mode, input bit allow_broken);
        int lim, kind, n;
        logic [7:0] gap;
        lim  = mode ? SEP_LEN : CMP_LEN;
        kind = allow_broken ? $urandom_range(0, 99) : 0;
        gap  = $urandom_range(0, 1) ? CH_T : CH_SPACE;
        fill_text(mode, pick_year(), pick_field(1, 12), pick_field(1, 31),
                  pick_field(0, 23), pick_field(0, 59), pick_field(0, 59), gap);
        n = lim;
        if (kind >= 93) begin
            // plain noise
            n = $urandom_range(1, 24);
            for (int p = 0; p < n; p++)
                text_buf[p] = 8'($urandom_range(0, 255));
        end else if (kind >= 85) begin
            // cut short or run long
            n = $urandom_range(1, lim + 6);
            for (int p = lim; p < n; p++)
                text_buf[p] = CH_ZERO + 8'($urandom_range(0, 9));
        end else if (kind >= 75) begin
            // one character replaced by anything
            text_buf[$urandom_range(0, lim - 1)] = 8'($urandom_range(0, 255));
        end
        send_text(n);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_compact_directed();
        write_mode(1'b0);
        send_str("19700101000000", 1);   // epoch itself
        send_str("99991231235959", 1);   // largest plain date
        send_str("99999999999999", 1);   // all nines: month carry, still fits in 48 bits
        send_str("19700100000000", 1);   // day 00 of the epoch month: negative
        send_str("19691231235959", 1);   // before 1970
        send_str("20240000120000", 1);   // month 00
        send_str("19691300000000", 1);   // month 13 carries into 1970
        send_str("20000229120000", 1);   // leap century
        send_str("21000301000000", 1);   // non-leap century
        send_str("2024a229120000", 1);   // non-digit
        send_str("202402291200", 1);     // short
        send_str("202402291200000", 1);  // long
        send_str("2024-02-29 12:00:00", 1);  // separated text in compact mode
        send_char(8'h00, 1'b0);          // character code extremes
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_separated_directed();
        write_mode(1'b1);
        send_str("1970-01-01 00:00:00", 1);
        send_str("2024-02-29T23:59:59", 1);
        send_str("9999-12-31T23:59:59", 1);
        send_str("2024-02-29t23:59:59", 1);  // lower-case t is not a separator
        send_str("2024/02-29 23:59:59", 1);
        send_str("2024-02-29 23-59:59", 1);
        send_str("1969-12-31 23:59:59", 1);
        send_str("2024-00-10 10:00:00", 1);
        send_str("2024-02-29 12:3x:56", 1);
        send_str("2024-02-29 12:34", 1);
        send_str("2024-02-29 12:34:567", 1);
        send_str("20240229120000", 1);       // compact text in separated mode
    endtask

    // each character obeys the mode in force when it is taken
    task automatic test_mode_switch_mid_text();
        write_mode(1'b0);
        send_str("2024031", 0);
        write_mode(1'b1);
        send_str("-15 08:30:00", 1);
        send_str("1999-12", 0);
        write_mode(1'b0);
        send_str("5081530", 1);   // day tens digit left over from the month
    endtask

    // output held off while requests keep coming: parser queue fills, input stalls
    task automatic test_output_stall();
        src_gaps  = 0;
        sink_hold = STALL_HOLD;
        for (int i = 0; i < 30; i++)
            send_random_text(cur_mode, 0);
        wait_drained();
        src_gaps = 1;
    endtask

    task automatic test_random_mix();
        int start;
        for (int phase = 0; phase < 8; phase++) begin
            // last stretch runs at full rate on both sides
            if (phase >= 6) begin
                src_gaps  = 0;
                sink_gaps = 0;
            end
            write_mode(phase == 0 ? 1'b0 : phase == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
            start = chars_taken;
            while (chars_taken - start < PHASE_CHARS)
                send_random_text(cur_mode, 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cur_mode = 1'b0;
        src_gaps  = 1;
        sink_gaps = 1;
        sink_hold  = 0;
        sink_stall = 0;
        fault_count = 0;
        chars_taken = 0;
        results_seen = 0;
        ok_seen = 0;
        malformed_seen = 0;
        range_seen = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_compact_directed();
        test_separated_directed();
        test_mode_switch_mid_text();
        test_output_stall();
        test_random_mix();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Both text formats, mid-text mode changes, output stalls and broken texts");
        $display("%0d characters, %0d results: %0d ok, %0d malformed, %0d out of range",
                 chars_taken, results_seen, ok_seen, malformed_seen, range_seen);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/dtem_pkg.sv
sv/dtem_front.sv
sv/dtem_queue.sv
sv/dtem_back.sv
sv/datetime_text_to_epoch_ms.sv
sv/dtem_checker.sv
bench/datetime_text_to_epoch_ms_test.sv
